// ----- hdl/sipgen_pkg.sv -----
// Shared constants, command and status types for the SipHash counter-mode generator.
`default_nettype none

package sipgen_pkg;

    localparam int MaxRequestBytes = 128;
    localparam int WordBytes       = 8;
    localparam int RemW            = $clog2(MaxRequestBytes + 1);
    localparam int CntW            = (RemW > 8) ? RemW : 8;

    localparam logic CfgKeyLow  = 1'b0;
    localparam logic CfgKeyHigh = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_REQ,
        OP_INIT,
        OP_ROUND_A,
        OP_ROUND_B,
        OP_MIX1,
        OP_MIX2,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/sipgen_dp.sv -----
// Datapath: key and counter registers, SipHash state with half-round unit, output register.
`default_nettype none

module sipgen_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [63:0]         cfg_wdata,
    input  wire logic [7:0]          s_tdata,
    input  wire sipgen_pkg::dp_cmd_t cmd,
    output sipgen_pkg::dp_stat_t     stat,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [63:0]              m_tdata,
    output logic [3:0]               m_tuser,
    output logic                     m_tlast
);
    import sipgen_pkg::*;

    localparam logic [63:0] InitC0 = 64'h736f6d6570736575;
    localparam logic [63:0] InitC1 = 64'h646f72616e646f6d;
    localparam logic [63:0] InitC2 = 64'h6c7967656e657261;
    localparam logic [63:0] InitC3 = 64'h7465646279746573;
    localparam logic [63:0] Tail   = 64'h0800000000000000;
    localparam logic [63:0] FinXor = 64'h00000000000000ff;

    logic [63:0]     key_low_reg, key_high_reg;
    logic [63:0]     ctr_reg, ctr_next;
    logic [RemW-1:0] rem_reg, rem_next;
    logic [63:0]     v0_reg, v1_reg, v2_reg, v3_reg;
    logic [63:0]     v0_next, v1_next, v2_next, v3_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [63:0]     m_tdata_reg;
    logic [3:0]      m_tuser_reg;
    logic            m_tlast_reg;

    logic [CntW-1:0] req_ext;
    logic [RemW-1:0] req_sat;
    logic            rem_le8;
    logic [3:0]      take;
    logic [63:0]     sum_a0, sum_a2, sum_b0, sum_b2;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    // request saturation and per-word byte accounting
    always_comb begin
        req_ext = CntW'(s_tdata);
        req_sat = (req_ext > CntW'(MaxRequestBytes)) ? RemW'(MaxRequestBytes)
                                                     : RemW'(req_ext);
        rem_le8 = (rem_reg <= RemW'(WordBytes));
        take    = rem_le8 ? rem_reg[3:0] : 4'(WordBytes);
    end

    assign sum_a0 = v0_reg + v1_reg;
    assign sum_a2 = v2_reg + v3_reg;
    assign sum_b0 = v0_reg + v3_reg;
    assign sum_b2 = v2_reg + v1_reg;

    always_comb begin
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        v3_next       = v3_reg;
        ctr_next      = ctr_reg;
        rem_next      = rem_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (cmd.op)
            OP_LOAD_REQ: begin
                rem_next = req_sat;
            end
            OP_INIT: begin
                v0_next = key_low_reg ^ InitC0;
                v1_next = key_high_reg ^ InitC1;
                v2_next = key_low_reg ^ InitC2;
                v3_next = key_high_reg ^ InitC3 ^ ctr_reg;
            end
            // first half of a SipRound
            OP_ROUND_A: begin
                v0_next = rotl(sum_a0, 32);
                v1_next = rotl(v1_reg, 13) ^ sum_a0;
                v2_next = sum_a2;
                v3_next = rotl(v3_reg, 16) ^ sum_a2;
            end
            // second half of a SipRound
            OP_ROUND_B: begin
                v0_next = sum_b0;
                v1_next = rotl(v1_reg, 17) ^ sum_b2;
                v2_next = rotl(sum_b2, 32);
                v3_next = rotl(v3_reg, 21) ^ sum_b0;
            end
            OP_MIX1: begin
                v0_next = v0_reg ^ ctr_reg;
                v3_next = v3_reg ^ Tail;
            end
            OP_MIX2: begin
                v0_next = v0_reg ^ Tail;
                v2_next = v2_reg ^ FinXor;
            end
            OP_EMIT: begin
                ctr_next      = ctr_reg + 64'd1;
                rem_next      = rem_reg - RemW'(take);
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            ctr_reg      <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CfgKeyLow:  key_low_reg  <= cfg_wdata;
                    CfgKeyHigh: key_high_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            ctr_reg      <= ctr_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v0_reg <= v0_next;
        v1_reg <= v1_next;
        v2_reg <= v2_next;
        v3_reg <= v3_next;
        if (cmd.op == OP_EMIT) begin
            m_tdata_reg <= v0_reg ^ v1_reg ^ v2_reg ^ v3_reg;
            m_tuser_reg <= take;
            m_tlast_reg <= rem_le8;
        end
    end

    assign stat.rem_zero = (rem_reg == '0);
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> !(m_tvalid_reg && !m_tready))
        else $error("word emitted over an untaken beat");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |=> m_tvalid_reg)
        else $error("emitted word not presented");

    a_valid_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg != 4'd0 && m_tuser_reg <= 4'(WordBytes)))
        else $error("valid byte count out of range");

    a_last_drains_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT && rem_le8) |=> (rem_reg == '0 && m_tlast_reg))
        else $error("last word left bytes pending");

endmodule

`default_nettype wire

// ----- hdl/sipgen_ctrl.sv -----
// Controller: sequences request load, SipHash init, half-rounds, mixing and word emission.
`default_nettype none

module sipgen_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire sipgen_pkg::dp_stat_t stat,
    output sipgen_pkg::dp_cmd_t       cmd
);
    import sipgen_pkg::*;

    // half-round indices that close the message, tail and finalization phases
    localparam logic [3:0] EndMsgRounds  = 4'd3;
    localparam logic [3:0] EndTailRounds = 4'd7;
    localparam logic [3:0] EndFinRounds  = 4'd15;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_RND   = 6'b000100,
        ST_MIX1  = 6'b001000,
        ST_MIX2  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD_REQ;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.rem_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.op     = OP_INIT;
                    rnd_next   = '0;
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                cmd.op   = rnd_reg[0] ? OP_ROUND_B : OP_ROUND_A;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == EndMsgRounds) begin
                    state_next = ST_MIX1;
                end else if (rnd_reg == EndTailRounds) begin
                    state_next = ST_MIX2;
                end else if (rnd_reg == EndFinRounds) begin
                    state_next = ST_FIN;
                end
            end
            ST_MIX1: begin
                cmd.op     = OP_MIX1;
                state_next = ST_RND;
            end
            ST_MIX2: begin
                cmd.op     = OP_MIX2;
                state_next = ST_RND;
            end
            ST_FIN: begin
                // hold the hash until the output register frees up
                if (!stat.out_busy) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/siphash_counter_mode_generator.sv -----
// Top level: SipHash-2-4 counter-mode random word generator.
// Each word runs the start (init) state, 16 half-rounds on the shared round unit, the two mix
// states and the emit state, which waits while the output register still holds an untaken word.
// s_tready stays low until a request's last word is emitted; a zero byte count skips the rounds.
// The output register lets the next request in while the last word still waits on m_tready.
// Reset (aresetn, synchronous, active low) clears key, counter and m_tvalid; the controller idles.
`default_nettype none

module siphash_counter_mode_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] byte_count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [63:0] random_word
    output logic [3:0]       m_tuser,    // [3:0] valid_bytes
    output logic             m_tlast
);
    import sipgen_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sipgen_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sipgen_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
